[rtl/core/fqd_pkg.sv]
// Shared types, constants and helpers of the FM quadrature demodulator.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fqd_pkg;

    // fixed-point fraction bits of the sample and angle format
    localparam int FRAC_BITS = 10;

    // pi/4 and 3pi/4 with a 32-bit fraction, rescaled to FRAC_BITS
    localparam logic [63:0] QUARTER_PI_Q32       = 64'd3373259426;
    localparam logic [63:0] THREE_QUARTER_PI_Q32 = 64'd10119778278;
    localparam logic [31:0] QUARTER_PI       = 32'(QUARTER_PI_Q32 >> (32 - FRAC_BITS));
    localparam logic [31:0] THREE_QUARTER_PI = 32'(THREE_QUARTER_PI_Q32 >> (32 - FRAC_BITS));

    // added to negative values so the arithmetic shift truncates towards zero
    localparam logic [31:0] DQ_BIAS = 32'((64'd1 << FRAC_BITS) - 64'd1);

    localparam logic [15:0] GAIN_RESET = 16'd758;

    typedef struct packed {
        logic signed [31:0] sample_real;
        logic signed [31:0] sample_imag;
        logic               last_in_block;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] demod_sample;
        logic               last_out;
    } t_out_item;

    // work handed from the front to the back: current and previous sample
    typedef struct packed {
        logic [31:0] cur_re;
        logic [31:0] cur_im;
        logic [31:0] prev_re;
        logic [31:0] prev_im;
        logic        last;
    } t_cmd;

    // status of the back end
    typedef struct packed {
        logic idle;
        logic res_push;
    } t_eng_stat;

    // truncating division of a wrapped 32-bit value by 2^FRAC_BITS
    function automatic logic [31:0] dequant(input logic [31:0] v);
        logic [31:0]        biased;
        logic signed [31:0] s;
        begin
            biased = v + (v[31] ? DQ_BIAS : 32'd0);
            s      = signed'(biased);
            return 32'(s >>> FRAC_BITS);
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/fqd_front.sv]
// Front end: accepts input items, pairs each with the previous sample and
// queues the pair for the back end. Depends on fqd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    input  fqd_pkg::t_in_item    i_in_item,
    output logic                 full,
    input  wire logic            i_cmd_pop,
    output logic                 o_cmd_valid,
    output fqd_pkg::t_cmd        o_cmd
);
    import fqd_pkg::*;

    t_cmd        r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic [31:0] r_prev_re;
    logic [31:0] r_prev_im;
    logic        w_acc;
    logic        w_take;
    t_cmd        w_cmd;

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_acc       = push && !full;
    assign w_take      = i_cmd_pop && o_cmd_valid;

    // pair the new sample with the one before it
    always_comb begin
        w_cmd.cur_re  = i_in_item.sample_real;
        w_cmd.cur_im  = i_in_item.sample_imag;
        w_cmd.prev_re = r_prev_re;
        w_cmd.prev_im = r_prev_im;
        w_cmd.last    = i_in_item.last_in_block;
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    // pointers, occupancy and previous sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= 1'b0;
            r_rd      <= 1'b0;
            r_cnt     <= 2'd0;
            r_prev_re <= 32'd0;
            r_prev_im <= 32'd0;
        end else begin
            if (w_acc) begin
                r_wr      <= ~r_wr;
                r_prev_re <= i_in_item.sample_real;
                r_prev_im <= i_in_item.sample_imag;
            end
            if (w_take) begin
                r_rd <= ~r_rd;
            end
            if (w_acc && !w_take) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_acc && w_take) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/fqd_engine.sv]
// Back end: conjugate product, quadrant arctangent with an iterative divider
// and gain scaling, one shared 32x32 multiplier. Depends on fqd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqd_engine (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [15:0]      i_gain,
    input  wire logic             i_cmd_valid,
    input  fqd_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_pop,
    input  wire logic             i_res_full,
    output fqd_pkg::t_out_item    o_res,
    output fqd_pkg::t_eng_stat    o_stat
);
    import fqd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_AY    = 4'd2;
    localparam logic [3:0] S_ND    = 4'd3;
    localparam logic [3:0] S_MAG   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_RATIO = 4'd6;
    localparam logic [3:0] S_MQ    = 4'd7;
    localparam logic [3:0] S_ANG   = 4'd8;
    localparam logic [3:0] S_NEGA  = 4'd9;
    localparam logic [3:0] S_MG    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]  r_state;
    logic [2:0]  r_k;
    logic [4:0]  r_dcnt;
    logic [31:0] r_re, r_im, r_pr, r_npi;
    logic        r_last;
    logic [31:0] r_p;
    logic [31:0] r_cr, r_ci;
    logic [31:0] r_ay;
    logic        r_xneg, r_yneg;
    logic [31:0] r_num, r_den;
    logic [31:0] r_rem, r_quo, r_dmag;
    logic        r_qneg, r_dzero;
    logic [31:0] r_ratio;
    logic [31:0] r_ang;

    logic [31:0] w_ma, w_mb, w_prod;
    logic [31:0] w_dq;
    logic [31:0] w_shift;
    logic [32:0] w_diff;
    logic        w_push;

    assign w_dq   = dequant(r_p);
    assign w_push = (r_state == S_OUT) && !i_res_full;

    assign o_cmd_pop       = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res.demod_sample = signed'(w_dq);
    assign o_res.last_out  = r_last;
    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.res_push = w_push;

    // shared multiplier operand select, low 32 bits kept
    always_comb begin
        w_ma = 32'd0;
        w_mb = 32'd0;
        unique case (r_state)
            S_MUL: begin
                case (r_k)
                    3'd0: begin w_ma = r_pr;  w_mb = r_re; end
                    3'd1: begin w_ma = r_npi; w_mb = r_im; end
                    3'd2: begin w_ma = r_pr;  w_mb = r_im; end
                    3'd3: begin w_ma = r_npi; w_mb = r_re; end
                    default: begin w_ma = 32'd0; w_mb = 32'd0; end
                endcase
            end
            S_MQ: begin
                w_ma = QUARTER_PI;
                w_mb = r_ratio;
            end
            S_MG: begin
                w_ma = {16'd0, i_gain};
                w_mb = r_ang;
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // one restoring divider step on magnitudes
    assign w_shift = {r_rem[30:0], r_quo[31]};
    assign w_diff  = {1'b0, w_shift} - {1'b0, r_dmag};

    // datapath registers
    always_ff @(posedge i_clk) begin
        // the scaled result stays in r_p while it waits for the queue
        if (r_state != S_OUT) begin
            r_p <= w_prod;
        end
        unique case (r_state)
            S_IDLE: begin
                r_re   <= i_cmd.cur_re;
                r_im   <= i_cmd.cur_im;
                r_pr   <= i_cmd.prev_re;
                r_npi  <= 32'd0 - i_cmd.prev_im;
                r_last <= i_cmd.last;
            end
            S_MUL: begin
                // accumulate the product held in r_p
                case (r_k)
                    3'd1: r_cr <= w_dq;
                    3'd2: r_cr <= r_cr - w_dq;
                    3'd3: r_ci <= w_dq;
                    3'd4: r_ci <= r_ci + w_dq;
                    default: r_cr <= r_cr;
                endcase
            end
            S_AY: begin
                r_ay   <= (r_ci[31] ? (32'd0 - r_ci) : r_ci) + 32'd1;
                r_yneg <= r_ci[31];
            end
            S_ND: begin
                r_xneg <= r_cr[31];
                if (!r_cr[31]) begin
                    r_num <= (r_cr - r_ay) << FRAC_BITS;
                    r_den <= r_cr + r_ay;
                end else begin
                    r_num <= (r_cr + r_ay) << FRAC_BITS;
                    r_den <= r_ay - r_cr;
                end
            end
            S_MAG: begin
                r_rem   <= 32'd0;
                r_quo   <= r_num[31] ? (32'd0 - r_num) : r_num;
                r_dmag  <= r_den[31] ? (32'd0 - r_den) : r_den;
                r_qneg  <= r_num[31] ^ r_den[31];
                r_dzero <= (r_den == 32'd0);
            end
            S_DIV: begin
                if (!w_diff[32]) begin
                    r_rem <= w_diff[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
            S_RATIO: begin
                if (r_dzero) begin
                    r_ratio <= 32'd0;
                end else if (r_qneg) begin
                    r_ratio <= 32'd0 - r_quo;
                end else begin
                    r_ratio <= r_quo;
                end
            end
            S_ANG: begin
                r_ang <= (r_xneg ? THREE_QUARTER_PI : QUARTER_PI) - w_dq;
            end
            S_NEGA: begin
                if (r_yneg) begin
                    r_ang <= 32'd0 - r_ang;
                end
            end
            default: begin
                r_ang <= r_ang;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 3'd0;
            r_dcnt  <= 5'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= S_MUL;
                        r_k     <= 3'd0;
                    end
                end
                S_MUL: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) begin
                        r_state <= S_AY;
                    end
                end
                S_AY:  r_state <= S_ND;
                S_ND:  r_state <= S_MAG;
                S_MAG: begin
                    r_state <= S_DIV;
                    r_dcnt  <= 5'd0;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_state <= S_RATIO;
                    end
                end
                S_RATIO: r_state <= S_MQ;
                S_MQ:    r_state <= S_ANG;
                S_ANG:   r_state <= S_NEGA;
                S_NEGA:  r_state <= S_MG;
                S_MG:    r_state <= S_OUT;
                S_OUT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/fqd_res_q.sv]
// Two-entry result queue between the back end and the output port.
// Depends on fqd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqd_res_q (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  fqd_pkg::t_out_item   i_item,
    output logic                 o_full,
    output logic                 empty,
    input  wire logic            pop,
    output fqd_pkg::t_out_item   o_item
);
    import fqd_pkg::*;

    t_out_item  r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full = (r_cnt == 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign o_item = r_q[r_rd];
    assign w_wr   = i_push && !o_full;
    assign w_rd   = pop && !empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr] <= i_item;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr <= ~r_wr;
            end
            if (w_rd) begin
                r_rd <= ~r_rd;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_wr && w_rd) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/fm_quadrature_demodulator.sv]
// FM quadrature demodulator top level. Depends on fqd_pkg, fqd_front,
// fqd_engine and fqd_res_q.
// The back-end sequencer works on one item at a time, in 5 multiply steps, a
// 32-step restoring divider and 10 setup and finish steps, and takes the next
// item only from idle. An accepted item passes through the front queue, the
// back end and the result queue to o_out_item. Reset: synchronous active-low
// i_rst_n clears both queues, the previous sample and sets the gain to 758.
`timescale 1ns / 1ps
`default_nettype none

module fm_quadrature_demodulator (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    output logic                 full,
    input  fqd_pkg::t_in_item    i_in_item,
    output logic                 empty,
    input  wire logic            pop,
    output fqd_pkg::t_out_item   o_out_item,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [15:0]     i_cfg_data
);
    import fqd_pkg::*;

    logic        [15:0] r_gain;
    logic               w_cmd_valid;
    logic               w_cmd_pop;
    t_cmd               w_cmd;
    t_out_item          w_res;
    logic               w_res_full;
    t_eng_stat          w_stat;

    assign o_cfg_ready = 1'b1;

    // gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gain <= i_cfg_data;
        end
    end

    fqd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in_item   (i_in_item),
        .full        (full),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    fqd_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (r_gain),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res       (w_res),
        .o_stat      (w_stat)
    );

    fqd_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_stat.res_push),
        .i_item  (w_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_out_item)
    );

    // the back end never writes into a full result queue
    a_no_res_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_push |-> !w_res_full)
        else $error("result written into full queue");

    // the back end starts work only on a queued item
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.idle && !w_cmd_valid) |=> w_stat.idle)
        else $error("back end left idle without an item");

    // no result is visible straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // an item is handed to the back end only while it is idle
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> (w_stat.idle && w_cmd_valid))
        else $error("item taken while back end busy");

endmodule

`default_nettype wire

[tb/fm_quadrature_demodulator_tb.sv]
// Self-checking testbench for the FM quadrature demodulator.
// Depends on fqd_pkg and fm_quadrature_demodulator; a built-in predictor checks every item.
`timescale 1ns / 1ps

module fm_quadrature_demodulator_tb;

    import fqd_pkg::*;

    // fixed-point format and angle constants of the discriminator
    localparam int          SHIFT_BITS = 10;
    localparam logic [63:0] PI4_Q32    = 64'd3373259426;
    localparam logic [63:0] PI34_Q32   = 64'd10119778278;
    localparam logic [31:0] ANG_PI4    = 32'(PI4_Q32 >> (32 - SHIFT_BITS));
    localparam logic [31:0] ANG_PI34   = 32'(PI34_Q32 >> (32 - SHIFT_BITS));
    localparam logic [15:0] GAIN_AT_RESET = 16'd758;

    // timing: settling, end-of-run and stall limits
    localparam int SETTLE_CYCLES = 64;
    localparam int END_CYCLES    = 120;
    localparam int STALL_LIMIT   = 4000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_item   in_item = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [15:0] cfg_data = '0;

    // predictor state
    t_out_item   demod_expected_q[$];
    logic [31:0] hist_re = '0;
    logic [31:0] hist_im = '0;
    logic [15:0] gain_now = GAIN_AT_RESET;

    int n_errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_gain_writes = 0;
    int idle_cycles = 0;
    int send_gap_max = 8;
    int recv_gap_max = 8;

    fm_quadrature_demodulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // divide by 2^SHIFT_BITS, rounding towards zero
    function automatic logic [31:0] trunc_scale(input logic [31:0] v);
        longint s;
        longint q;
        s = signed'(v);
        q = s / (64'sd1 << SHIFT_BITS);
        return q[31:0];
    endfunction

    // signed 32-bit quotient; zero divisor gives 0, overflow wraps
    function automatic logic [31:0] wrap_div(input logic [31:0] num, input logic [31:0] den);
        longint n;
        longint d;
        longint q;
        if (den == 32'd0)
            return 32'd0;
        n = signed'(num);
        d = signed'(den);
        q = n / d;
        return q[31:0];
    endfunction

    // one-division quadrant arctangent of y/x
    function automatic logic [31:0] quadrant_atan(input logic [31:0] y, input logic [31:0] x);
        logic [31:0] mag_y;
        logic [31:0] ratio;
        logic [31:0] ang;
        mag_y = y[31] ? 32'd0 - y : y;
        mag_y = mag_y + 32'd1;
        if (!x[31]) begin
            ratio = wrap_div((x - mag_y) << SHIFT_BITS, x + mag_y);
            ang   = ANG_PI4 - trunc_scale(ANG_PI4 * ratio);
        end else begin
            ratio = wrap_div((x + mag_y) << SHIFT_BITS, mag_y - x);
            ang   = ANG_PI34 - trunc_scale(ANG_PI4 * ratio);
        end
        return y[31] ? 32'd0 - ang : ang;
    endfunction

    // conjugate product of previous and current sample, angle, gain
    function automatic logic [31:0] discriminate(input logic [31:0] pr, input logic [31:0] pim,
                                                 input logic [31:0] re, input logic [31:0] im,
                                                 input logic [15:0] g);
        logic [31:0] npi;
        logic [31:0] cr;
        logic [31:0] ci;
        logic [31:0] ang;
        logic [31:0] g32;
        npi = 32'd0 - pim;
        cr  = trunc_scale(pr * re) - trunc_scale(npi * im);
        ci  = trunc_scale(pr * im) + trunc_scale(npi * re);
        ang = quadrant_atan(ci, cr);
        g32 = {16'd0, g};
        return trunc_scale(g32 * ang);
    endfunction

    // accepted input items: predict and advance the sample history
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && push && !full) begin
            exp_item.demod_sample = discriminate(hist_re, hist_im, in_item.sample_real,
                                                 in_item.sample_imag, gain_now);
            exp_item.last_out     = in_item.last_in_block;
            demod_expected_q.push_back(exp_item);
            hist_re = in_item.sample_real;
            hist_im = in_item.sample_imag;
            n_items++;
        end
    end

    // gain register writes
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_valid && cfg_ready) begin
            gain_now = cfg_data;
            n_gain_writes++;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && pop && !empty) begin
            n_results++;
            if (demod_expected_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected item: expected none, got %0d/%0b",
                         $time, out_item.demod_sample, out_item.last_out);
            end else begin
                exp_item = demod_expected_q.pop_front();
                if (out_item.demod_sample !== exp_item.demod_sample) begin
                    n_errors++;
                    $display("%0t: demod_sample mismatch: expected %0d, got %0d",
                             $time, exp_item.demod_sample, out_item.demod_sample);
                end
                if (out_item.last_out !== exp_item.last_out) begin
                    n_errors++;
                    $display("%0t: last_out mismatch: expected %0b, got %0b",
                             $time, exp_item.last_out, out_item.last_out);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d items outstanding",
                     $time, idle_cycles, demod_expected_q.size());
            $display("** fm_quadrature_demodulator: FAILED **");
            $finish;
        end
    end

    // result side: random stall before each item, pop held high otherwise
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, recv_gap_max);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty)
                @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_in_item make_sample(input int re, input int im, input bit last);
        t_in_item it;
        it.sample_real   = re;
        it.sample_imag   = im;
        it.last_in_block = last;
        return it;
    endfunction

    function automatic t_in_item noise_sample(input bit last);
        return make_sample(int'($urandom), int'($urandom), last);
    endfunction

    function automatic t_in_item tone_sample(input int amp, input bit last);
        int re;
        int im;
        re = int'($urandom_range(0, 2 * amp)) - amp;
        im = int'($urandom_range(0, 2 * amp)) - amp;
        return make_sample(re, im, last);
    endfunction

    // push stays high after acceptance so back-to-back items need no re-arm
    task automatic send_sample(input t_in_item it);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    task automatic stop_sending();
        push <= 1'b0;
    endtask

    // sender pauses until every expected item has come back
    task automatic wait_drain();
        stop_sending();
        @(posedge i_clk);
        while (demod_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [15:0] g);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // blocks of random length ending in the marker; mostly moderate tones,
    // some full-range noise and some misplaced markers
    task automatic send_blocks(input int count);
        int sent;
        int len;
        int amp;
        bit last;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 16);
            case ($urandom_range(0, 2))
                0: amp = $urandom_range(1, 64);
                1: amp = $urandom_range(64, 4096);
                default: amp = $urandom_range(4096, 1 << 21);
            endcase
            for (int k = 0; k < len && sent < count; k++) begin
                last = (k == len - 1);
                if ($urandom_range(0, 19) == 0)
                    last = !last;
                if ($urandom_range(0, 9) < 8)
                    send_sample(tone_sample(amp, last));
                else
                    send_sample(noise_sample(last));
                sent++;
            end
        end
    endtask

    // prev = (1024, 0) makes the next sample the conjugate product itself,
    // so each quadrant and sign can be steered directly
    task automatic send_corner_cases();
        send_sample(make_sample(0, 0, 1'b0));            // zero history after reset
        send_sample(make_sample(1024, 0, 1'b0));
        send_sample(make_sample(3000, -700, 1'b0));      // right half, y below zero
        send_sample(make_sample(1024, 0, 1'b0));
        send_sample(make_sample(-3000, 700, 1'b0));      // left half
        send_sample(make_sample(1024, 0, 1'b0));
        send_sample(make_sample(-3000, -700, 1'b1));     // left half, y below zero
        send_sample(make_sample(1024, 0, 1'b0));
        send_sample(make_sample(-1, -1, 1'b0));          // rounding towards zero
        send_sample(make_sample(32'h7fffffff, 32'h7fffffff, 1'b0));
        send_sample(make_sample(32'h80000000, 32'h80000000, 1'b1));
        send_sample(make_sample(32'h80000000, 32'h7fffffff, 1'b0));
        send_sample(make_sample(32'h7fffffff, 32'h80000000, 1'b0));
        send_sample(make_sample(-1, 0, 1'b0));
        send_sample(make_sample(1024, 0, 1'b0));
        send_sample(make_sample(0, 5000, 1'b0));         // x zero, y above zero
        send_sample(make_sample(1024, 0, 1'b0));
        send_sample(make_sample(0, -5000, 1'b1));        // x zero, y below zero
        send_sample(make_sample(1, 1, 1'b0));
        send_sample(make_sample(-1023, 1023, 1'b1));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // corner cases with the gain left at its reset value
    task automatic test_reset_gain();
        send_gap_max = 8;
        recv_gap_max = 8;
        send_corner_cases();
    endtask

    // gain at zero, full scale and one
    task automatic test_gain_extremes();
        write_gain(16'd0);
        send_blocks(30);
        write_gain(16'hffff);
        send_corner_cases();
        send_blocks(30);
        write_gain(16'd1);
        send_blocks(20);
    endtask

    // sender holds off mid-stream until everything is back
    task automatic test_sender_pause();
        write_gain(GAIN_AT_RESET);
        send_blocks(40);
        wait_drain();
        send_blocks(40);
    endtask

    // long random run over several gains and idling patterns
    task automatic test_random_blocks();
        for (int ph = 0; ph < 6; ph++) begin
            write_gain(16'($urandom_range(0, 65535)));
            case (ph % 3)
                0: begin send_gap_max = 8; recv_gap_max = 8; end
                1: begin send_gap_max = 0; recv_gap_max = 0; end
                default: begin send_gap_max = 0; recv_gap_max = 8; end
            endcase
            send_blocks(125);
        end
        send_gap_max = 8;
        recv_gap_max = 8;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_gain();
        test_gain_extremes();
        test_sender_pause();
        test_random_blocks();

        stop_sending();
        @(posedge i_clk);
        while (demod_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples and checked %0d demodulated items, %0d gain writes.",
                 n_items, n_results, n_gain_writes);
        $display("Mismatches: %0d, still outstanding: %0d.",
                 n_errors, demod_expected_q.size());
        if (n_errors == 0 && demod_expected_q.size() == 0)
            $display("** fm_quadrature_demodulator: PASSED **");
        else
            $display("** fm_quadrature_demodulator: FAILED **");
        $finish;
    end

endmodule
